// ----- rtl/camera_result_frame_parser_top_defines.svh -----
// assertion macros used by the checker file
`ifndef CAMERA_RESULT_FRAME_PARSER_TOP_DEFINES_SVH
`define CAMERA_RESULT_FRAME_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define CRFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crfp assertion failed");

// next-cycle implication, disabled while reset is held
`define CRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crfp assertion failed");

`endif

// ----- rtl/crfp_pkg.sv -----
package crfp_pkg;

  // fixed field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned Slots    = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned OutDataW = 40;

  // first frame byte that lands in the payload store, and counter ceiling
  localparam logic [CountW-1:0] PayloadFirst = 4'd2;
  localparam logic [CountW-1:0] CountMax     = 4'd15;

  // register indexes on the config port
  localparam logic [CfgIdxW-1:0] RegHeaderFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeaderSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] RegEndMarker    = 2'd2;

  // register reset values
  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'h2C;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'h12;
  localparam logic [ByteW-1:0] EndMarkerRst    = 8'h5B;

  // parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HDR1    = 3'b001,
    PH_HDR2    = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic [15:0]      y_position;
    logic [15:0]      x_position;
    logic [ByteW-1:0] color_code;
  } result_t;

endpackage

// ----- rtl/crfp_parser.sv -----
module crfp_parser #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [7:0]                rx_byte_i,
  input  crfp_pkg::cfg_t            cfg_i,
  output logic                      emit_o,
  output crfp_pkg::result_t         result_o
);
  import crfp_pkg::*;

  localparam logic [CountW-1:0] FrameBytesC = CountW'(FRAME_BYTES);

  phase_e              phase_q, phase_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [ByteW-1:0]    store_q [Slots];
  logic [ByteW-1:0]    store_d [Slots];
  logic [CountW-1:0]   count_inc;
  logic                frame_end;

  // next state of the frame parser
  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    store_d   = store_q;
    emit_o    = 1'b0;
    count_inc = (count_q < CountMax) ? count_q + 4'd1 : count_q;
    frame_end = (count_inc >= FrameBytesC) || (count_inc == CountMax)
                || (rx_byte_i == cfg_i.end_marker);
    case (phase_q)
      PH_HDR1: begin
        if (rx_byte_i == cfg_i.header_first) begin
          phase_d = PH_HDR2;
          count_d = 4'd1;
        end else begin
          count_d = '0;
          for (int i = 0; i < Slots; i++) store_d[i] = '0;
        end
      end
      PH_HDR2: begin
        if (rx_byte_i == cfg_i.header_second) begin
          phase_d = PH_PAYLOAD;
          count_d = 4'd2;
        end else begin
          phase_d = PH_HDR1;
          count_d = '0;
          for (int i = 0; i < Slots; i++) store_d[i] = '0;
        end
      end
      PH_PAYLOAD: begin
        // frame bytes past the last slot are counted only
        for (int i = 0; i < Slots; i++) begin
          if (count_q == PayloadFirst + CountW'(i)) store_d[i] = rx_byte_i;
        end
        count_d = count_inc;
        if (frame_end) begin
          emit_o  = 1'b1;
          phase_d = PH_HDR1;
          count_d = '0;
        end
      end
      default: begin
        phase_d = PH_HDR1;
        count_d = '0;
        for (int i = 0; i < Slots; i++) store_d[i] = '0;
      end
    endcase
  end

  // result built from the store including this beat
  assign result_o.color_code = store_d[0];
  assign result_o.x_position = {store_d[1], store_d[2]};
  assign result_o.y_position = {store_d[3], store_d[4]};

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR1;
      count_q <= '0;
      for (int i = 0; i < Slots; i++) store_q[i] <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      store_q <= store_d;
    end
  end

endmodule

// ----- rtl/camera_result_frame_parser_top.sv -----
// Camera result frame parser. Each input beat carries one received byte. A
// frame is the header_first byte, the header_second byte, then payload; it
// ends when the byte count (headers included) reaches FRAME_BYTES (7 to 10),
// when the count reaches 15, or on an end_marker byte, which is itself
// stored. Each finished frame yields one output beat: color code and
// big-endian x and y from the five payload slots; slots not written in this
// frame keep older values, and any header mismatch clears them. A byte is
// registered at the input, then decoded and its result loaded into the
// output register, so a byte goes in every cycle while the sink takes results.
// One byte can wait in the input register while a result is held by the sink.
// Registers are to be written on the config port only while the block is idle;
// the block itself does not enforce this.
module camera_result_frame_parser_top #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [7:0] color_code, [23:8] x_position,
                                      // [39:24] y_position
);
  import crfp_pkg::*;

  cfg_t              cfg_q;
  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_valid_q, out_valid_d;
  result_t           out_data_q;
  logic              advance;
  logic              emit;
  result_t           result;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= HeaderFirstRst;
      cfg_q.header_second <= HeaderSecondRst;
      cfg_q.end_marker    <= EndMarkerRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegHeaderFirst:  cfg_q.header_first  <= cfg_data_i;
        RegHeaderSecond: cfg_q.header_second <= cfg_data_i;
        RegEndMarker:    cfg_q.end_marker    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input stage moves on when the output register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_byte_q <= s_axis_tdata;
  end

  crfp_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .rx_byte_i(in_byte_q),
    .cfg_i    (cfg_q),
    .emit_o   (emit),
    .result_o (result)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (advance && emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) out_data_q <= result;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);

endmodule

// ----- rtl/crfp_chk.sv -----
`include "camera_result_frame_parser_top_defines.svh"

module crfp_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  logic out_stall;
  logic in_beat;

  // handshake shorthands
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_beat   = s_axis_tvalid && s_axis_tready;

  // a held result keeps its data
  `CRFP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // input stalls only behind a result the sink refuses
  `CRFP_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, !s_axis_tready, out_stall)

  // a fresh result follows an earlier input beat through the input and output registers
  `CRFP_ASSERT_NOW(a_out_source, clk_i, rst_ni, $rose(m_axis_tvalid), $past(in_beat, 2))

endmodule

bind camera_result_frame_parser_top crfp_chk u_crfp_chk (.*);
